// File: rtl/core/mbad_pkg.sv
// Package for the masked block average disparity block.
// Holds payload structs, register indexes, size limits and controller/datapath command types.
// No dependencies.
package mbad_pkg;

   localparam int MaxTileColumns = 4096;
   localparam int MaxTileSide    = 64;
   localparam int MaxImageSide   = 4096;
   localparam int ColBits        = 12;
   localparam int SumBits        = 28;
   localparam int CntBits        = 13;
   localparam int QuoBits        = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_BLOCK_WIDTH   = 3'd2,
      REG_BLOCK_HEIGHT  = 3'd3,
      REG_MIN_DISPARITY = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] raw_disparity;
      logic               frame_start;
   } req_word_type;

   typedef struct packed {
      logic [11:0]        tile_column;
      logic [11:0]        tile_row;
      logic signed [19:0] mean_disparity;
      logic               mean_valid;
      logic               frame_last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word
      logic rd;         // read accumulator of current column
      logic accum;      // update accumulator, advance positions
      logic div_start;  // start the divider
      logic div_step;   // one divider iteration
      logic emit;       // load the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_range;
      logic tile_done;
      logic div_done;
      logic clearing;   // accumulator memories being zeroed after reset
   } dp_status_type;

endpackage

// File: rtl/core/masked_block_average_disparity.sv
// Masked block average disparity: per tile mean of valid raw disparity pixels.
// A new pixel is accepted only in the idle state, after the last one is read and accumulated;
// a tile closing pixel also runs the bit per cycle restoring divider and waits for a free output.
// Accumulator memory is one word per tile column, read once per pixel, written for in-range tiles.
// Reset: synchronous, active high; registers return to their reset values, positions zero,
// then a pass over all 4096 columns zeroes the accumulators while req_ready stays low.
module masked_block_average_disparity (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mbad_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mbad_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data
);

   mbad_pkg::dp_cmd_type    cmd;
   mbad_pkg::dp_status_type status;
   logic                    rsp_valid_ff;

   // configuration is always taken
   assign csr_ready = 1'b1;

   mbad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_busy  (rsp_valid_ff && !rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mbad_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_data),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_word_ff (rsp_data)
   );

   // output word register valid; hold until taken
   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.emit)   rsp_valid_ff <= 1'b1;
      else if (rsp_ready)  rsp_valid_ff <= 1'b0;
   end
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("emit over a waiting word");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rd, cmd.accum, cmd.emit}))
      else $error("overlapping commands");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted word not shown");
`endif

endmodule

// File: rtl/core/mbad_ctrl.sv
// Controller state machine for the masked block average disparity block.
// Depends on mbad_pkg.
module mbad_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_busy,
   output mbad_pkg::dp_cmd_type   cmd,
   input  mbad_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_ACCUM, ST_DIV, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !status.clearing;
            if (req_valid && !status.clearing) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.in_range && status.tile_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: rtl/core/mbad_datapath.sv
// Datapath: position counters, per column accumulator memories and a restoring divider.
// Depends on mbad_pkg.
module mbad_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mbad_pkg::req_word_type  req_word,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  mbad_pkg::dp_cmd_type    cmd,
   output mbad_pkg::dp_status_type status,
   output mbad_pkg::rsp_word_type  rsp_word_ff
);

   localparam int CB = mbad_pkg::ColBits;
   localparam int QB = mbad_pkg::QuoBits;

   logic [12:0]        image_width_ff, image_height_ff;
   logic [6:0]         block_width_ff, block_height_ff;
   logic signed [11:0] min_disp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 13'd640;
         image_height_ff <= 13'd480;
         block_width_ff  <= 7'd8;
         block_height_ff <= 7'd8;
         min_disp_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mbad_pkg::REG_IMAGE_WIDTH:   image_width_ff  <= csr_data[12:0];
            mbad_pkg::REG_IMAGE_HEIGHT:  image_height_ff <= csr_data[12:0];
            mbad_pkg::REG_BLOCK_WIDTH:   block_width_ff  <= csr_data[6:0];
            mbad_pkg::REG_BLOCK_HEIGHT:  block_height_ff <= csr_data[6:0];
            mbad_pkg::REG_MIN_DISPARITY: min_disp_ff     <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // clamped sizes
   logic [12:0] w, h;
   logic [6:0]  bw, bh;
   always_comb begin
      w  = (image_width_ff == '0) ? 13'd1 :
           (image_width_ff > 13'(mbad_pkg::MaxImageSide)) ? 13'(mbad_pkg::MaxImageSide)
           : image_width_ff;
      h  = (image_height_ff == '0) ? 13'd1 :
           (image_height_ff > 13'(mbad_pkg::MaxImageSide)) ? 13'(mbad_pkg::MaxImageSide)
           : image_height_ff;
      bw = (block_width_ff == '0) ? 7'd1 :
           (block_width_ff > 7'(mbad_pkg::MaxTileSide)) ? 7'(mbad_pkg::MaxTileSide)
           : block_width_ff;
      bh = (block_height_ff == '0) ? 7'd1 :
           (block_height_ff > 7'(mbad_pkg::MaxTileSide)) ? 7'(mbad_pkg::MaxTileSide)
           : block_height_ff;
   end

   logic [12:0] px_ff, py_ff;
   logic [6:0]  itx_ff, ity_ff;
   logic [12:0] col_ff, row_ff;
   logic signed [15:0] raw_ff;
   logic        fs_ff;

   logic [12:0] px, py, col, row;
   logic [6:0]  itx, ity;
   always_comb begin
      if (fs_ff) begin
         px = '0; py = '0; col = '0; row = '0; itx = '0; ity = '0;
      end else begin
         px = px_ff; py = py_ff; col = col_ff; row = row_ff; itx = itx_ff; ity = ity_ff;
      end
   end

   // tile in range iff the whole tile fits: (col+1)*bw <= w, (row+1)*bh <= h, col < MaxTileColumns
   logic [19:0] cend, cend_n, rend, rend_n;
   logic        in_range, tile_done, last_col, last_row;
   assign cend      = (20'(col) + 20'd1) * 20'(bw);
   assign cend_n    = cend + 20'(bw);
   assign rend      = (20'(row) + 20'd1) * 20'(bh);
   assign rend_n    = rend + 20'(bh);
   assign in_range  = (cend <= 20'(w)) && (rend <= 20'(h))
                      && (col < 13'(mbad_pkg::MaxTileColumns));
   assign tile_done = (8'(itx) + 8'd1 >= 8'(bw)) && (8'(ity) + 8'd1 >= 8'(bh));
   assign last_col  = (cend_n > 20'(w)) || (col == 13'(mbad_pkg::MaxTileColumns - 1));
   assign last_row  = rend_n > 20'(h);

   // accumulator memories
   logic signed [mbad_pkg::SumBits-1:0] sum_mem [mbad_pkg::MaxTileColumns];
   logic [mbad_pkg::CntBits-1:0]        cnt_mem [mbad_pkg::MaxTileColumns];
   logic signed [mbad_pkg::SumBits-1:0] sum_rd_ff;
   logic [mbad_pkg::CntBits-1:0]        cnt_rd_ff;
   logic [CB:0]                         clr_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         sum_rd_ff <= sum_mem[col[CB-1:0]];
         cnt_rd_ff <= cnt_mem[col[CB-1:0]];
      end
   end

   logic first, pix_ok;
   logic signed [16:0] ceiling;
   logic signed [mbad_pkg::SumBits-1:0] s_new;
   logic [mbad_pkg::CntBits-1:0]        c_new;
   assign ceiling = (17'(min_disp_ff) - 17'sd1) <<< 4;
   assign first   = (itx == '0) && (ity == '0);
   assign pix_ok  = 17'(raw_ff) > ceiling;
   always_comb begin
      s_new = first ? '0 : sum_rd_ff;
      c_new = first ? '0 : cnt_rd_ff;
      if (pix_ok) begin
         s_new = s_new + mbad_pkg::SumBits'(raw_ff);
         c_new = c_new + 1'b1;
      end
   end

   // zero every column once after reset, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset)          clr_ff <= '0;
      else if (!clr_ff[CB]) clr_ff <= clr_ff + (CB+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (!clr_ff[CB]) begin
         sum_mem[clr_ff[CB-1:0]] <= '0;
         cnt_mem[clr_ff[CB-1:0]] <= '0;
      end else if (cmd.accum && in_range) begin
         sum_mem[col[CB-1:0]] <= s_new;
         cnt_mem[col[CB-1:0]] <= c_new;
      end
   end

   // capture request word, advance positions
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_word.raw_disparity;
         fs_ff  <= req_word.frame_start;
      end
      if (reset) begin
         px_ff <= '0; py_ff <= '0; col_ff <= '0; row_ff <= '0;
         itx_ff <= '0; ity_ff <= '0;
      end else if (cmd.accum) begin
         if (px + 13'd1 >= w) begin
            px_ff <= '0; itx_ff <= '0; col_ff <= '0;
            if (py + 13'd1 >= h) begin
               py_ff <= '0; ity_ff <= '0; row_ff <= '0;
            end else begin
               py_ff <= py + 13'd1;
               if (ity + 7'd1 >= bh) begin
                  ity_ff <= '0; row_ff <= row + 13'd1;
               end else begin
                  ity_ff <= ity + 7'd1; row_ff <= row;
               end
            end
         end else begin
            px_ff <= px + 13'd1; py_ff <= py; ity_ff <= ity; row_ff <= row;
            if (itx + 7'd1 >= bw) begin
               itx_ff <= '0; col_ff <= col + 13'd1;
            end else begin
               itx_ff <= itx + 7'd1; col_ff <= col;
            end
         end
      end
   end

   // restoring divider on |s|*16 / c, one bit a cycle
   logic [QB-1:0] quo_ff, rem_ff;
   logic [mbad_pkg::CntBits-1:0] div_ff;
   logic [5:0]  step_ff;
   logic        neg_ff, mvalid_ff, flast_ff;
   logic [11:0] tcol_ff, trow_ff;
   logic [QB:0] trial;
   logic [mbad_pkg::SumBits-1:0] mag;

   assign mag   = s_new[mbad_pkg::SumBits-1] ? -s_new : s_new;
   assign trial = {rem_ff, quo_ff[QB-1]} - (QB+1)'(div_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         quo_ff    <= QB'({mag, 4'b0});
         rem_ff    <= '0;
         div_ff    <= c_new;
         neg_ff    <= s_new[mbad_pkg::SumBits-1];
         mvalid_ff <= c_new != '0;
         flast_ff  <= last_col && last_row;
         tcol_ff   <= col[11:0];
         trow_ff   <= row[11:0];
         step_ff   <= 6'(QB);
      end else if (cmd.div_step && step_ff != '0) begin
         step_ff <= step_ff - 6'd1;
         if (!trial[QB]) begin
            rem_ff <= trial[QB-1:0];
            quo_ff <= {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[QB-2:0], quo_ff[QB-1]};
            quo_ff <= {quo_ff[QB-2:0], 1'b0};
         end
      end
   end

   assign status.in_range  = in_range;
   assign status.tile_done = tile_done;
   assign status.div_done  = step_ff == 6'd1;
   assign status.clearing  = !clr_ff[CB];

   logic [QB-1:0] q_signed;
   assign q_signed = neg_ff ? -quo_ff : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_word_ff.tile_column    <= tcol_ff;
         rsp_word_ff.tile_row       <= trow_ff;
         rsp_word_ff.mean_disparity <= mvalid_ff ? q_signed[19:0] : '0;
         rsp_word_ff.mean_valid     <= mvalid_ff;
         rsp_word_ff.frame_last     <= flast_ff;
      end
   end

endmodule

// File: bench/masked_block_average_disparity_tb.sv
// Self-checking bench for the masked block average disparity block.
// Predicts per tile means from the pixel stream and compares every result word.
// Depends on mbad_pkg and the masked_block_average_disparity RTL.
`timescale 1ns / 1ps

module masked_block_average_disparity_tb;

   // Tile mean predictor and store of expected result words.
   class tile_mean_board;
      logic [12:0] img_w, img_h;
      logic [6:0]  blk_w, blk_h;
      logic [11:0] min_disp;
      logic signed [31:0] col_sum [mbad_pkg::MaxTileColumns];
      int unsigned col_cnt [mbad_pkg::MaxTileColumns];
      int unsigned px, py, tx, ty, tcol, trow;
      mbad_pkg::rsp_word_type pending_q[$];
      int errors;
      int results_seen;

      function void clear_pos();
         px = 0; py = 0; tx = 0; ty = 0; tcol = 0; trow = 0;
      endfunction

      function void reset_state();
         img_w = 640; img_h = 480; blk_w = 8; blk_h = 8; min_disp = 0;
         foreach (col_sum[i]) begin
            col_sum[i] = 0;
            col_cnt[i] = 0;
         end
         clear_pos();
         pending_q.delete();
         errors = 0;
         results_seen = 0;
      endfunction

      function void write_reg(mbad_pkg::reg_index_type idx, logic [31:0] val);
         case (idx)
            mbad_pkg::REG_IMAGE_WIDTH:   img_w = val[12:0];
            mbad_pkg::REG_IMAGE_HEIGHT:  img_h = val[12:0];
            mbad_pkg::REG_BLOCK_WIDTH:   blk_w = val[6:0];
            mbad_pkg::REG_BLOCK_HEIGHT:  blk_h = val[6:0];
            mbad_pkg::REG_MIN_DISPARITY: min_disp = val[11:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_side(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      // note one accepted pixel; queue the tile mean when it closes a tile
      function void note_pixel(mbad_pkg::req_word_type w);
         int signed raw, ceil_v, s;
         int unsigned iw, ih, bw, bh, cols, rows, c;
         longint signed mean;
         mbad_pkg::rsp_word_type r;
         raw = w.raw_disparity;
         ceil_v = ($signed(min_disp) - 1) * 16;
         iw = clamp_side(img_w, mbad_pkg::MaxImageSide);
         ih = clamp_side(img_h, mbad_pkg::MaxImageSide);
         bw = clamp_side(blk_w, mbad_pkg::MaxTileSide);
         bh = clamp_side(blk_h, mbad_pkg::MaxTileSide);
         cols = iw / bw;
         rows = ih / bh;
         if (cols > mbad_pkg::MaxTileColumns) cols = mbad_pkg::MaxTileColumns;
         if (w.frame_start) clear_pos();
         if (tcol < cols && trow < rows) begin
            s = (tx == 0 && ty == 0) ? 0 : col_sum[tcol];
            c = (tx == 0 && ty == 0) ? 0 : col_cnt[tcol];
            if (raw > ceil_v) begin
               s += raw;
               c++;
            end
            col_sum[tcol] = s;
            col_cnt[tcol] = c;
            if (tx + 1 >= bw && ty + 1 >= bh) begin
               mean = 0;
               if (c > 0) mean = (longint'(s) * 16) / longint'(c);
               r.tile_column = tcol[11:0];
               r.tile_row = trow[11:0];
               r.mean_disparity = mean[19:0];
               r.mean_valid = (c > 0);
               r.frame_last = (tcol + 1 == cols && trow + 1 == rows);
               pending_q.push_back(r);
            end
         end
         px++;
         tx++;
         if (tx >= bw) begin
            tx = 0;
            tcol++;
         end
         if (px >= iw) begin
            px = 0; tx = 0; tcol = 0;
            py++;
            ty++;
            if (ty >= bh) begin
               ty = 0;
               trow++;
            end
            if (py >= ih) clear_pos();
         end
      endfunction

      function void check_result(mbad_pkg::rsp_word_type got);
         mbad_pkg::rsp_word_type exp_w;
         results_seen++;
         if (pending_q.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            errors++;
            return;
         end
         exp_w = pending_q.pop_front();
         if (got.tile_column !== exp_w.tile_column) begin
            $error("tile_column exp %0d got %0d", exp_w.tile_column, got.tile_column);
            errors++;
         end
         if (got.tile_row !== exp_w.tile_row) begin
            $error("tile_row exp %0d got %0d", exp_w.tile_row, got.tile_row);
            errors++;
         end
         if (got.mean_disparity !== exp_w.mean_disparity) begin
            $error("mean_disparity exp %0d got %0d", exp_w.mean_disparity,
                   got.mean_disparity);
            errors++;
         end
         if (got.mean_valid !== exp_w.mean_valid) begin
            $error("mean_valid exp %0b got %0b", exp_w.mean_valid, got.mean_valid);
            errors++;
         end
         if (got.frame_last !== exp_w.frame_last) begin
            $error("frame_last exp %0b got %0b", exp_w.frame_last, got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mbad_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mbad_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   tile_mean_board board = new();
   int pixels_sent = 0;
   int frames_run = 0;
   bit hold_off = 1'b0;     // long receiver stall request
   logic [15:0] raw_ones = '0, raw_zeros = '0;

   masked_block_average_disparity dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly zero or short, now and then long.
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Score each accepted result word at the edge it moves.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // Receiver: random ready, plus a long hold-off when requested.
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic write_csr(mbad_pkg::reg_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // Offer one pixel word and hold it until accepted; predict on acceptance.
   task automatic send_pixel(logic signed [15:0] raw, logic fs, bit allow_gap);
      int gap;
      if (allow_gap) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= '{raw_disparity: raw, frame_start: fs};
      do @(posedge clock); while (!req_ready);
      board.note_pixel('{raw_disparity: raw, frame_start: fs});
      raw_ones |= raw;
      raw_zeros |= ~raw;
      pixels_sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every expected word has come, then let the divider drain.
   task automatic wait_drained();
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_geometry(int w, int h, int bw, int bh, int md);
      write_csr(mbad_pkg::REG_IMAGE_WIDTH, w);
      write_csr(mbad_pkg::REG_IMAGE_HEIGHT, h);
      write_csr(mbad_pkg::REG_BLOCK_WIDTH, bw);
      write_csr(mbad_pkg::REG_BLOCK_HEIGHT, bh);
      write_csr(mbad_pkg::REG_MIN_DISPARITY, md);
   endtask

   // Random pixel value: mostly near the invalid ceiling, some extremes.
   function logic signed [15:0] pick_raw(int md);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return 16'($urandom_range(0, 16'hFFFF));
      if (roll == 2) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      return 16'((md - 1) * 16 + $signed($urandom_range(0, 64)) - 32);
   endfunction

   // Stream whole frames of one geometry with random content.
   task automatic run_frames(int w, int h, int bw, int bh, int md, int n_frames,
                             bit noisy);
      set_geometry(w, h, bw, bh, md);
      for (int f = 0; f < n_frames; f++) begin
         for (int i = 0; i < w * h; i++) begin
            // noise: a spurious frame start breaks the raster now and then
            send_pixel(pick_raw(md),
                       (i == 0 && $urandom_range(0, 1)) ||
                       (noisy && $urandom_range(0, 30) == 0), 1'b1);
         end
         frames_run++;
      end
      stop_sending();
      wait_drained();
   endtask

   initial begin
      int md;
      board.reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, tile with invalid pixels, ceiling edge, frame start
      set_geometry(4, 2, 2, 2, 0);
      send_pixel(16'sh7FFF, 1'b1, 1'b0);
      send_pixel(16'sh7FFF, 1'b0, 1'b0);
      send_pixel(-16'sd16, 1'b0, 1'b0);   // at the ceiling: invalid
      send_pixel(-16'sd15, 1'b0, 1'b0);
      send_pixel(16'sh7FFF, 1'b0, 1'b0);
      send_pixel(16'sh7FFF, 1'b0, 1'b0);
      send_pixel(16'sh8000, 1'b0, 1'b0);  // below the ceiling: invalid
      send_pixel(16'sh8000, 1'b0, 1'b0);
      send_pixel(-16'sd1, 1'b1, 1'b0);    // frame start after a full frame
      stop_sending();
      wait_drained();
      set_geometry(0, 0, 0, 0, 12'h800);  // zero sizes, most negative floor
      send_pixel(16'sh8000, 1'b0, 1'b0);
      send_pixel(-16'sd3, 1'b0, 1'b0);
      stop_sending();
      wait_drained();
      write_csr(mbad_pkg::REG_MIN_DISPARITY, 32'h7FF);
      send_pixel(16'sh7FFF, 1'b0, 1'b0);
      stop_sending();
      wait_drained();
      // edge pixels and oversized block side
      set_geometry(5, 3, 100, 2, 1);
      for (int i = 0; i < 15; i++) send_pixel(16'(i * 7 - 20), i == 0, 1'b0);
      stop_sending();
      wait_drained();

      // long receiver stall while the sender keeps pushing
      hold_off = 1'b1;
      run_frames(4, 4, 1, 1, 0, 2, 1'b0);

      // random part over several geometries, extremes included
      while (pixels_sent < 1000) begin
         md = $urandom_range(0, 3) == 0 ? 1024 - $urandom_range(0, 2048) :
              $signed($urandom_range(0, 8)) - 4;
         case ($urandom_range(0, 5))
            0: run_frames(8, 6, 2, 3, md, 2, 1'b0);
            1: run_frames(12, 4, 4, 4, md, 2, 1'b1);
            2: run_frames(9, 5, 3, 1, md, 3, 1'b0);
            3: run_frames(64, 2, 64, 1, md, 1, 1'b0);
            4: run_frames(3, 3, 1, 2, md, 4, 1'b1);
            default: run_frames(7, 7, 7, 7, md, 2, 1'b0);
         endcase
      end
      // big frame sides with the largest blocks: only part of one line
      set_geometry(4096, 1, 64, 1, 0);
      for (int i = 0; i < 128; i++) send_pixel(pick_raw(0), i == 0, 1'b0);
      stop_sending();
      wait_drained();
      write_csr(mbad_pkg::REG_IMAGE_WIDTH, 32'h1FFF);
      write_csr(mbad_pkg::REG_IMAGE_HEIGHT, 32'h1FFF);
      write_csr(mbad_pkg::REG_BLOCK_WIDTH, 32'h7F);
      write_csr(mbad_pkg::REG_BLOCK_HEIGHT, 32'h7F);
      write_csr(mbad_pkg::REG_MIN_DISPARITY, 32'h400);
      for (int i = 0; i < 64; i++) send_pixel(pick_raw(1024), i == 0, 1'b1);
      stop_sending();
      wait_drained();

      $display("Covered %0d pixel words in %0d random frames, %0d tile results.",
               pixels_sent, frames_run, board.results_seen);
      if (raw_ones !== 16'hFFFF || raw_zeros !== 16'hFFFF)
         $display("Note: not every raw_disparity bit toggled.");
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
